// ===== hdl/tama_pkg.sv =====
`default_nettype none
package tama_pkg;

  localparam int MAX_WINDOW_DEF   = 20;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int AXES             = 3;
  localparam int BYPASS_BELOW     = 2;
  localparam int RATE_W           = 16;
  localparam int DIV_BITS         = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/tama_ram.sv =====
`default_nettype none
module tama_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/tama_div.sv =====
`default_nettype none
module tama_div #(
  parameter int SUM_W        = 29,
  parameter int CNT_W        = 5,
  parameter int SAMPLE_WIDTH = 24,
  parameter int DIV_STEPS    = 4
) (
  input  logic                           clk,
  input  logic                           load,
  input  logic                           step,
  input  logic signed [SUM_W-1:0]        dividend,
  input  logic [CNT_W-1:0]               divisor,
  output logic signed [SAMPLE_WIDTH-1:0] quotient
);

  localparam int DIVW = DIV_STEPS * tama_pkg::DIV_BITS;

  logic [DIVW-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic              neg_r;
  logic signed [DIVW-1:0] ext;
  logic [DIVW-1:0]   mag;
  logic [DIVW-1:0]   res;

  assign ext = DIVW'(dividend);
  assign mag = ext[DIVW-1] ? DIVW'(-ext) : DIVW'(ext);

  always_comb begin
    logic [CNT_W:0]   sh;
    logic [CNT_W-1:0] rem_v;
    logic [DIVW-1:0]  q_v;
    rem_v = rem_r;
    q_v   = q_r;
    for (int k = 0; k < tama_pkg::DIV_BITS; k++) begin
      sh  = {rem_v, q_v[DIVW-1]};
      q_v = {q_v[DIVW-2:0], 1'b0};
      if (sh >= {1'b0, divisor}) begin
        sh     = sh - {1'b0, divisor};
        q_v[0] = 1'b1;
      end
      rem_v = sh[CNT_W-1:0];
    end
    rem_nxt = rem_v;
    q_nxt   = q_v;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r   <= mag;
      rem_r <= '0;
      neg_r <= dividend[SUM_W-1];
    end else if (step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign res      = neg_r ? (~q_r + DIVW'(1)) : q_r;
  assign quotient = res[SAMPLE_WIDTH-1:0];

endmodule
`default_nettype wire

// ===== hdl/tama_ctrl.sv =====
`default_nettype none
module tama_ctrl #(
  parameter int DIV_STEPS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tama_pkg::status_t status,
  output tama_pkg::cmd_t    cmd
);

  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  tama_pkg::state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              last_step;

  assign last_step = (step_r == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tama_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = status.bypass ? tama_pkg::S_DONE : tama_pkg::S_UPDATE;
        end
      end
      tama_pkg::S_UPDATE: state_nxt = tama_pkg::S_LOAD;
      tama_pkg::S_LOAD:   state_nxt = tama_pkg::S_DIV;
      tama_pkg::S_DIV: begin
        if (last_step) begin
          state_nxt = tama_pkg::S_DONE;
        end
      end
      tama_pkg::S_DONE: begin
        if (status.out_free) begin
          state_nxt = tama_pkg::S_IDLE;
        end
      end
      default: state_nxt = tama_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    step_nxt  = step_r;
    unique case (state_r)
      tama_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      tama_pkg::S_UPDATE: cmd.update = 1'b1;
      tama_pkg::S_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
      end
      tama_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
      end
      tama_pkg::S_DONE: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tama_pkg::S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tama_dp.sv =====
`default_nettype none
module tama_dp #(
  parameter int MAX_WINDOW   = 20,
  parameter int SAMPLE_WIDTH = 24,
  parameter int DIV_STEPS    = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tama_pkg::RATE_W-1:0]       cfg_wdata,
  input  logic [tama_pkg::AXES*SAMPLE_WIDTH-1:0] in_data,
  input  tama_pkg::cmd_t                    cmd,
  output tama_pkg::status_t                 status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tama_pkg::AXES*SAMPLE_WIDTH-1:0] out_data
);

  localparam int AXES  = tama_pkg::AXES;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int SUM_W = SAMPLE_WIDTH + CNT_W;
  localparam int RING_W = AXES * SAMPLE_WIDTH;

  logic [tama_pkg::RATE_W-1:0] rate_r;
  logic [CNT_W-1:0] active_r, filled_r;
  logic [PTR_W-1:0] pos_r;
  logic             full_r, byp_r;
  logic signed [SAMPLE_WIDTH-1:0] smp_r [AXES];
  logic signed [SUM_W-1:0]        sum_r [AXES];
  logic signed [SAMPLE_WIDTH-1:0] quo [AXES];
  logic [RING_W-1:0] ring_rdata, ring_wdata;
  logic              out_valid_r;
  logic [RING_W-1:0] out_data_r;

  logic [CNT_W-1:0] win, base_filled;
  logic [PTR_W-1:0] base_pos;
  logic             changed, bypass;
  logic [CNT_W-1:0] pos_inc;

  assign bypass  = (rate_r < tama_pkg::RATE_W'(tama_pkg::BYPASS_BELOW));
  assign win     = (rate_r > tama_pkg::RATE_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW)
                                                             : rate_r[CNT_W-1:0];
  assign changed = (win != active_r);
  assign base_filled = changed ? '0 : filled_r;
  assign base_pos    = changed ? '0 : pos_r;
  assign pos_inc     = CNT_W'(pos_r) + CNT_W'(1);

  assign status.bypass   = bypass;
  assign status.out_free = !out_valid_r || out_ready;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ring_wdata[a*SAMPLE_WIDTH +: SAMPLE_WIDTH] = smp_r[a];
    end
  end

  tama_ram #(
    .WIDTH (RING_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (pos_r),
    .wdata (ring_wdata),
    .re    (cmd.capture),
    .raddr (base_pos),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
    end else if (cfg_we) begin
      rate_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      filled_r <= '0;
      pos_r    <= '0;
      full_r   <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum_r[a] <= '0;
      end
    end else if (cmd.capture && !bypass) begin
      active_r <= win;
      pos_r    <= base_pos;
      if (base_filled < win) begin
        filled_r <= base_filled + CNT_W'(1);
        full_r   <= 1'b0;
      end else begin
        filled_r <= base_filled;
        full_r   <= 1'b1;
      end
      if (changed) begin
        for (int a = 0; a < AXES; a++) begin
          sum_r[a] <= '0;
        end
      end
    end else if (cmd.update) begin
      for (int a = 0; a < AXES; a++) begin
        sum_r[a] <= sum_r[a]
                  - (full_r ? SUM_W'($signed(ring_rdata[a*SAMPLE_WIDTH +: SAMPLE_WIDTH]))
                            : SUM_W'(0))
                  + SUM_W'(smp_r[a]);
      end
      pos_r <= (pos_inc >= active_r) ? '0 : pos_inc[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byp_r <= bypass;
      for (int a = 0; a < AXES; a++) begin
        smp_r[a] <= $signed(in_data[a*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
      end
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_div
    tama_div #(
      .SUM_W        (SUM_W),
      .CNT_W        (CNT_W),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .DIV_STEPS    (DIV_STEPS)
    ) u_div (
      .clk      (clk),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (sum_r[g]),
      .divisor  (filled_r),
      .quotient (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int a = 0; a < AXES; a++) begin
        out_data_r[a*SAMPLE_WIDTH +: SAMPLE_WIDTH] <= byp_r ? smp_r[a] : quo[a];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_filled_le_window: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= active_r)
    else $error("fill count above window length");

  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r != '0) |-> (CNT_W'(pos_r) < active_r))
    else $error("ring position outside window");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_load |-> (filled_r != '0))
    else $error("division started with empty window");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// ===== hdl/three_axis_moving_average_top.sv =====
`default_nettype none
// Boxcar moving average of a three-axis field sample, signed fixed point, one
// result per request. The window is min(cfg rate, MAX_WINDOW) samples; a rate
// below 2 passes samples through. While the window fills, the mean is over the
// samples taken so far; changing the window length restarts the fill. Means
// truncate toward zero. A filtered request passes from acceptance to the result
// register through a ring read, sum update, divider load, then
// ceil((SAMPLE_WIDTH + clog2(MAX_WINDOW+1)) / 8) steps of the 8-bit-per-cycle
// restoring dividers, 4 at the defaults; a bypassed request skips them. The next
// request is taken once the previous result is in the output register.
module three_axis_moving_average_top #(
  parameter int MAX_WINDOW   = tama_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = tama_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [tama_pkg::RATE_W-1:0] cfg_wdata,
  input  logic in_tvalid,
  output logic in_tready,
  // field_x, field_y, field_z
  input  logic [((tama_pkg::AXES*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // mean_x, mean_y, mean_z
  output logic [((tama_pkg::AXES*SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata
);

  localparam int DATA_W    = tama_pkg::AXES * SAMPLE_WIDTH;
  localparam int TDATA_W   = ((DATA_W + 7) / 8) * 8;
  localparam int SUM_W     = SAMPLE_WIDTH + $clog2(MAX_WINDOW + 1);
  localparam int DIV_STEPS = (SUM_W + tama_pkg::DIV_BITS - 1) / tama_pkg::DIV_BITS;

  tama_pkg::cmd_t    cmd;
  tama_pkg::status_t status;
  logic [DATA_W-1:0] out_data;

  tama_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tama_dp #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DIV_STEPS    (DIV_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata[DATA_W-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = TDATA_W'(out_data);

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;

  localparam int SW          = tama_pkg::SAMPLE_WIDTH_DEF;
  localparam int WIN         = tama_pkg::MAX_WINDOW_DEF;
  localparam int NAX         = tama_pkg::AXES;
  localparam int DW          = ((NAX * SW + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 600000;

  typedef logic signed [SW-1:0] axis_t;
  typedef logic [tama_pkg::RATE_W-1:0] rate_t;

  typedef struct packed {
    axis_t z;
    axis_t y;
    axis_t x;
  } triple_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_THROTTLED
  } rx_mode_t;

  localparam axis_t AX_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam axis_t AX_MIN = {1'b1, {(SW-1){1'b0}}};

  class boxcar_scoreboard;
    rate_t       rate;
    int unsigned active_len;
    int unsigned filled;
    int unsigned slot;
    longint      history [WIN][NAX];
    longint      sums [NAX];
    triple_t     expected_means[$];
    int          failures;

    function new();
      rate       = '0;
      active_len = 0;
      filled     = 0;
      slot       = 0;
      sums       = '{default: 0};
      failures   = 0;
    endfunction

    function int pending();
      return expected_means.size();
    endfunction

    function void note_request(triple_t req);
      axis_t       s [NAX];
      axis_t       r [NAX];
      int unsigned len;
      bit          wrapped;
      s = '{req.x, req.y, req.z};
      if (rate < tama_pkg::BYPASS_BELOW) begin
        expected_means.push_back(req);
        return;
      end
      len = (rate > WIN) ? WIN : rate;
      if (len != active_len) begin
        active_len = len;
        filled     = 0;
        slot       = 0;
        sums       = '{default: 0};
      end
      wrapped = (filled >= active_len);
      if (!wrapped) filled++;
      for (int a = 0; a < NAX; a++) begin
        if (wrapped) sums[a] -= history[slot][a];
        history[slot][a] = longint'(s[a]);
        sums[a] += longint'(s[a]);
        r[a] = axis_t'(sums[a] / longint'(filled));
      end
      slot++;
      if (slot >= active_len) slot = 0;
      expected_means.push_back('{x: r[0], y: r[1], z: r[2]});
    endfunction

    function void check_result(triple_t got);
      triple_t want;
      if (expected_means.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result at %0t: x=%0d y=%0d z=%0d",
                   $time, got.x, got.y, got.z);
        return;
      end
      want = expected_means.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
        failures++;
        if (failures <= 10)
          $display("mean mismatch at %0t: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                   $time, want.x, want.y, want.z, got.x, got.y, got.z);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  rate_t         cfg_wdata = '0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [DW-1:0] out_tdata;

  boxcar_scoreboard sb = new();
  int       cycle_count = 0;
  int       items_sent = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;

  three_axis_moving_average_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(triple_t'(out_tdata[NAX*SW-1:0]));
    end
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 2));
      rx_mode_left <= $urandom_range(30, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:    out_tready <= 1'b1;
      RX_CHOPPY:  out_tready <= ($urandom_range(0, 1) == 1);
      default:    out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("three_axis_moving_average_top regression: fail");
    $finish;
  end

  function automatic axis_t random_axis();
    case ($urandom_range(0, 7))
      0:       return AX_MAX;
      1:       return AX_MIN;
      2:       return axis_t'($urandom_range(0, 64)) - axis_t'(32);
      default: return axis_t'($urandom());
    endcase
  endfunction

  task automatic send_sample(input axis_t x, input axis_t y, input axis_t z);
    triple_t req;
    int      gap;
    req = '{x: x, y: y, z: z};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= DW'(req);
    do @(posedge clk); while (!in_tready);
    sb.note_request(req);
    items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_rate(input rate_t value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.rate = value;
  endtask

  initial begin
    int    phase_len;
    rate_t rate;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(AX_MAX, AX_MIN, 24'sd0);
    send_sample(AX_MIN, AX_MAX, -24'sd1);
    write_rate(16'd1);
    send_sample(24'sh555555, 24'shAAAAAA, 24'sh123456);
    write_rate(16'd3);
    repeat (3) send_sample(AX_MAX, AX_MAX, AX_MIN);
    send_sample(AX_MIN, AX_MIN, AX_MAX);
    send_sample(AX_MIN, 24'sd7, -24'sd7);
    write_rate(16'd2);
    send_sample(-24'sd1, 24'sd1, -24'sd3);
    send_sample(24'sd0, 24'sd0, 24'sd0);
    send_sample(-24'sd2, 24'sd2, 24'sd5);
    write_rate(16'hFFFF);
    send_sample(AX_MAX, -24'sd5, 24'sd9);
    send_sample(AX_MAX, -24'sd6, 24'sd1);
    write_rate(16'd20);
    send_sample(AX_MIN, 24'sd3, -24'sd9);
    send_sample(-24'sd1, -24'sd1, -24'sd1);
    write_rate(16'd21);
    send_sample(24'sd1, 24'sd2, 24'sd3);

    while (items_sent < RANDOM_ITEMS + 16) begin
      case ($urandom_range(0, 6))
        0:       rate = rate_t'($urandom_range(0, 1));
        1, 2, 3: rate = rate_t'($urandom_range(2, WIN));
        4:       rate = rate_t'($urandom_range(WIN + 1, 16'hFFFF));
        5:       rate = rate_t'($urandom());
        default: rate = sb.rate;
      endcase
      write_rate(rate);
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        send_sample(random_axis(), random_axis(), random_axis());
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("three_axis_moving_average_top regression: pass");
    end else begin
      $display("three_axis_moving_average_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
